// ----- design/jdn_pkg.sv -----
// ----------------------------------------------------------------------------
// jdn_pkg
// Shared types, widths and constants of the Julian Day Number converter.
// ----------------------------------------------------------------------------
`default_nettype none

package jdn_pkg;

  // Field widths
  localparam int unsigned DN_W   = 23;
  localparam int unsigned CENT_W = 7;
  localparam int unsigned YIC_W  = 7;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned YEAR_W = 15;

  // APB configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic        REG_GREG_START = 1'b0;  // register index, paddr[2]
  localparam logic [DN_W-1:0] GREG_START_RST = 23'd2361222;

  // Mode codes
  localparam logic MODE_TO_DAY  = 1'b0;
  localparam logic MODE_TO_DATE = 1'b1;

  // Register stages from input register to last datapath stage
  localparam int unsigned PIPE_STAGES = 6;

  // Calendar offsets
  localparam logic [23:0] GREG_OFS     = 24'd32044;
  localparam logic [23:0] JUL_OFS      = 24'd32082;
  localparam logic [23:0] GREG_JDN_OFS = 24'd32045;
  localparam logic [23:0] JUL_JDN_OFS  = 24'd32083;
  localparam logic [14:0] YEAR_OFS     = 15'd4800;

  // Reciprocal constants: floor(x/D) == (x*MUL) >> SH over the whole input range
  localparam int unsigned B_DIV = 146097;
  localparam int unsigned B_SH  = 44;
  localparam int unsigned B_MW  = 27;
  localparam logic [B_MW-1:0] B_MUL =
    B_MW'(((64'd1 << B_SH) + 64'(B_DIV) - 64'd1) / 64'(B_DIV));

  localparam int unsigned D_DIV = 1461;
  localparam int unsigned D_SH  = 37;
  localparam int unsigned D_MW  = 27;
  localparam logic [D_MW-1:0] D_MUL =
    D_MW'(((64'd1 << D_SH) + 64'(D_DIV) - 64'd1) / 64'(D_DIV));

  localparam int unsigned M_DIV = 153;
  localparam int unsigned M_SH  = 19;
  localparam int unsigned M_MW  = 12;
  localparam logic [M_MW-1:0] M_MUL =
    M_MW'(((64'd1 << M_SH) + 64'(M_DIV) - 64'd1) / 64'(M_DIV));

  localparam int unsigned Q_DIV = 25;
  localparam int unsigned Q_SH  = 18;
  localparam int unsigned Q_MW  = 14;
  localparam logic [Q_MW-1:0] Q_MUL =
    Q_MW'(((64'd1 << Q_SH) + 64'(Q_DIV) - 64'd1) / 64'(Q_DIV));

  // Date result of the day-to-date path
  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [MON_W-1:0]         month;
    logic [DAY_W-1:0]         day;
    logic                     julian;
  } date_t;

  // Days before a shifted month (March is month 0): (153*m + 2) / 5
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] v;
    case (m)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      4'd12:   v = 9'd367;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- design/jdn_if.sv -----
// ----------------------------------------------------------------------------
// jdn_in_if / jdn_out_if
// Valid/ready channels carrying the converter's input and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface jdn_in_if import jdn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic              use_julian;
  logic [CENT_W-1:0] century;
  logic [YIC_W-1:0]  year_in_century;
  logic [MON_W-1:0]  month_in;
  logic [DAY_W-1:0]  day_in;
  logic [DN_W-1:0]   day_number_in;

  modport source (
    output valid, mode, use_julian, century, year_in_century, month_in, day_in,
           day_number_in,
    input  ready
  );
  modport sink (
    input  valid, mode, use_julian, century, year_in_century, month_in, day_in,
           day_number_in,
    output ready
  );
endinterface

interface jdn_out_if import jdn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [DN_W-1:0]          day_number_out;
  logic signed [YEAR_W-1:0] year_out;
  logic [MON_W-1:0]         month_out;
  logic [DAY_W-1:0]         day_out;
  logic                     julian_used;

  modport source (
    output valid, day_number_out, year_out, month_out, day_out, julian_used,
    input  ready
  );
  modport sink (
    input  valid, day_number_out, year_out, month_out, day_out, julian_used,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/jdn_to_date.sv -----
// ----------------------------------------------------------------------------
// jdn_to_date
// Five-stage day number to calendar date datapath, with a multiply in every stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jdn_to_date import jdn_pkg::*; (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [DN_W-1:0] day_number,
  input  wire logic [DN_W-1:0] greg_start,
  output date_t                date
);

  // Stage A: calendar select, century quotient
  logic [23:0] a_nxt;
  logic [25:0] xb;
  logic [52:0] b_prod;
  logic        jul_nxt;
  logic [7:0]  b_nxt;

  logic [DN_W-1:0] n_a_r;
  logic [23:0]     a_a_r;
  logic [7:0]      b_a_r;
  logic            jul_a_r;

  assign jul_nxt = (day_number < greg_start);
  assign a_nxt   = 24'(day_number) + GREG_OFS;
  assign xb      = {a_nxt, 2'b11};
  assign b_prod  = 53'(xb) * 53'(B_MUL);
  assign b_nxt   = jul_nxt ? 8'd0 : b_prod[B_SH +: 8];

  // Stage B: day within century (or Julian day count)
  logic [25:0] bp;
  logic [23:0] c_nxt;

  logic [23:0] c_b_r;
  logic [7:0]  b_b_r;
  logic        jul_b_r;

  assign bp    = 26'(b_a_r) * 26'(B_DIV);
  assign c_nxt = jul_a_r ? (24'(n_a_r) + JUL_OFS) : (a_a_r - bp[25:2]);

  // Stage C: year within cycle
  logic [25:0] xd;
  logic [52:0] d_prod;
  logic [14:0] d_nxt;

  logic [14:0] d_c_r;
  logic [23:0] c_c_r;
  logic [7:0]  b_c_r;
  logic        jul_c_r;

  assign xd     = {c_b_r, 2'b11};
  assign d_prod = 53'(xd) * 53'(D_MUL);
  assign d_nxt  = d_prod[D_SH +: 15];

  // Stage D: day within year
  logic [25:0] dp;
  logic [23:0] e_full;
  logic [8:0]  e_nxt;

  logic [8:0]  e_d_r;
  logic [14:0] d_d_r;
  logic [7:0]  b_d_r;
  logic        jul_d_r;

  assign dp     = 26'(d_c_r) * 26'(D_DIV);
  assign e_full = c_c_r - dp[25:2];
  assign e_nxt  = e_full[8:0];

  // Stage E: shifted month
  logic [10:0] xm;
  logic [22:0] m_prod;
  logic [3:0]  m_nxt;

  logic [3:0]  m_e_r;
  logic [8:0]  e_e_r;
  logic [14:0] d_e_r;
  logic [7:0]  b_e_r;
  logic        jul_e_r;

  assign xm     = 11'(e_d_r) * 11'd5 + 11'd2;
  assign m_prod = 23'(xm) * 23'(M_MUL);
  assign m_nxt  = m_prod[M_SH +: 4];

  always_ff @(posedge clk) begin
    if (en) begin
      n_a_r   <= day_number;
      a_a_r   <= a_nxt;
      b_a_r   <= b_nxt;
      jul_a_r <= jul_nxt;

      c_b_r   <= c_nxt;
      b_b_r   <= b_a_r;
      jul_b_r <= jul_a_r;

      d_c_r   <= d_nxt;
      c_c_r   <= c_b_r;
      b_c_r   <= b_b_r;
      jul_c_r <= jul_b_r;

      e_d_r   <= e_nxt;
      d_d_r   <= d_c_r;
      b_d_r   <= b_c_r;
      jul_d_r <= jul_c_r;

      m_e_r   <= m_nxt;
      e_e_r   <= e_d_r;
      d_e_r   <= d_d_r;
      b_e_r   <= b_d_r;
      jul_e_r <= jul_d_r;
    end
  end

  // Assemble year, month and day; year wraps to its field width
  logic        m10;
  logic [15:0] yr;
  logic [8:0]  dd;

  assign m10 = (m_e_r >= 4'd10);
  assign yr  = 16'(b_e_r) * 16'd100 + 16'(d_e_r) + 16'(m10) - 16'(YEAR_OFS);
  assign dd  = e_e_r - days_before(m_e_r) + 9'd1;

  assign date.year   = signed'(yr[YEAR_W-1:0]);
  assign date.month  = m10 ? (m_e_r - 4'd9) : (m_e_r + 4'd3);
  assign date.day    = dd[DAY_W-1:0];
  assign date.julian = jul_e_r;

endmodule

`default_nettype wire

// ----- design/julian_day_number_converter.sv -----
// ----------------------------------------------------------------------------
// julian_day_number_converter
// Two-way converter between calendar dates and Julian Day Numbers.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Word
//   in_chan   sink       valid/ready        mode, calendar flag, date, day number
//   out_chan  source     valid/ready        day number, year, month, day, calendar
//   APB       slave      psel/penable/ready Gregorian changeover day (address 0)
//
// One word is taken every clock cycle while no result is held at the output.
// Each word runs through an input register, five datapath stages and the
// result register; the depth is set by the chain of multiplies in the
// day-to-date path.
// While a result waits on out_chan the whole pipeline holds and in_chan.ready
// drops; it resumes in the cycle the result is taken.
// Reset (synchronous, rst_n low) clears all valid flags, holds in_chan.ready
// low and loads the changeover day with 2361222.
// ----------------------------------------------------------------------------
`default_nettype none

module julian_day_number_converter import jdn_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  jdn_in_if.sink                 in_chan,
  jdn_out_if.source              out_chan,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  // Per-stage control travelling alongside the data
  typedef struct packed {
    logic vld;
    logic mode;
    logic usej;
  } ctl_t;

  logic en;
  ctl_t ctl_r [PIPE_STAGES];

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [DN_W-1:0] greg_start_r;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_GREG_START);
  assign prdata = (paddr[2] == REG_GREG_START) ? APB_DW'(greg_start_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      greg_start_r <= GREG_START_RST;
    end else if (cfg_wr) begin
      greg_start_r <= pwdata[DN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: advance every stage unless a result is held at the output;
  // refuse input words while in reset
  // ---------------------------------------------------------------------------
  logic out_valid_r;

  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
        ctl_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl_r[0] <= '{vld: in_chan.valid, mode: in_chan.mode, usej: in_chan.use_julian};
      for (int i = 1; i < PIPE_STAGES; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
      out_valid_r <= ctl_r[PIPE_STAGES-1].vld;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic [CENT_W-1:0] cent_r;
  logic [YIC_W-1:0]  yic_r;
  logic [MON_W-1:0]  mon_r;
  logic [DAY_W-1:0]  day_r;
  logic [DN_W-1:0]   dn_in_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cent_r  <= in_chan.century;
      yic_r   <= in_chan.year_in_century;
      mon_r   <= in_chan.month_in;
      day_r   <= in_chan.day_in;
      dn_in_r <= in_chan.day_number_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Date to day number, stage A: shift the year to start in March and look
  // up the days before the shifted month. January and February (and month
  // zero) count as months of the previous year.
  // ---------------------------------------------------------------------------
  logic        early;
  logic [13:0] cent100;
  logic [14:0] y_nxt;
  logic [3:0]  mm;
  logic [9:0]  t0_nxt;

  logic [14:0] y_r;
  logic [9:0]  t0_r;

  assign early   = (mon_r <= 4'd2);
  assign cent100 = 14'(cent_r) * 14'd100;
  assign y_nxt   = 15'(cent100) + 15'(yic_r) + YEAR_OFS - 15'(early);
  assign mm      = early ? (mon_r + 4'd9) : (mon_r - 4'd3);
  assign t0_nxt  = 10'(days_before(mm)) + 10'(day_r);

  // Stage B: add year days and leap days; Gregorian drops the century
  // leap days that are not multiples of 400.
  logic [12:0] y4;
  logic [26:0] q_prod;
  logic [7:0]  q100;
  logic [5:0]  q400;
  logic [23:0] y365;
  logic [23:0] base;
  logic [23:0] sum_jul;
  logic [23:0] sum_greg;
  logic [DN_W-1:0] dn_nxt;

  assign y4       = y_r[14:2];
  assign q_prod   = 27'(y4) * 27'(Q_MUL);
  assign q100     = q_prod[Q_SH +: 8];
  assign q400     = q100[7:2];
  assign y365     = 24'(y_r) * 24'd365;
  assign base     = 24'(t0_r) + y365 + 24'(y4);
  assign sum_jul  = base - JUL_JDN_OFS;
  assign sum_greg = base + 24'(q400) - 24'(q100) - GREG_JDN_OFS;
  assign dn_nxt   = ctl_r[1].usej ? sum_jul[DN_W-1:0] : sum_greg[DN_W-1:0];

  // Day number travels stages B to E to line up with the date path
  logic [DN_W-1:0] dn_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      y_r      <= y_nxt;
      t0_r     <= t0_nxt;
      dn_r[0]  <= dn_nxt;
      for (int i = 1; i < 4; i++) begin
        dn_r[i] <= dn_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Day number to date
  // ---------------------------------------------------------------------------
  date_t date;

  jdn_to_date u_to_date (
    .clk        (clk),
    .en         (en),
    .day_number (dn_in_r),
    .greg_start (greg_start_r),
    .date       (date)
  );

  // ---------------------------------------------------------------------------
  // Result register: zero the fields the mode does not produce
  // ---------------------------------------------------------------------------
  logic [DN_W-1:0]          dn_out_r;
  logic signed [YEAR_W-1:0] year_out_r;
  logic [MON_W-1:0]         month_out_r;
  logic [DAY_W-1:0]         day_out_r;
  logic                     jul_out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl_r[PIPE_STAGES-1].mode == MODE_TO_DATE) begin
        dn_out_r    <= '0;
        year_out_r  <= date.year;
        month_out_r <= date.month;
        day_out_r   <= date.day;
        jul_out_r   <= date.julian;
      end else begin
        dn_out_r    <= dn_r[3];
        year_out_r  <= '0;
        month_out_r <= '0;
        day_out_r   <= '0;
        jul_out_r   <= ctl_r[PIPE_STAGES-1].usej;
      end
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.day_number_out = dn_out_r;
  assign out_chan.year_out       = year_out_r;
  assign out_chan.month_out      = month_out_r;
  assign out_chan.day_out        = day_out_r;
  assign out_chan.julian_used    = jul_out_r;

endmodule

`default_nettype wire
